@@ src/htd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the Huffman tree stream decoder.
// No dependencies; all files but htd_ram refer to it by scoped names.
package htd_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_NODES    = 511;
  localparam int STACK_DEPTH  = 256;

  localparam int SYM_W      = 8;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int NODE_AW    = $clog2(MAX_NODES + 1);
  localparam int NODE_DEPTH = 1 << NODE_AW;
  localparam int STACK_AW   = $clog2(STACK_DEPTH);

  localparam logic [SYM_W-1:0] CH_INTERNAL = 8'h49;
  localparam logic [SYM_W-1:0] CH_LEAF     = 8'h4C;

  typedef logic [NODE_AW-1:0]  node_idx_t;
  typedef logic [STACK_AW-1:0] stk_addr_t;
  typedef logic [STACK_AW:0]   stk_cnt_t;
  typedef logic [STACK_AW+1:0] stk_ext_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TREE  = 2'd0,
    OP_BIT   = 2'd1,
    OP_END   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SYMBOL   = 2'd0,
    ST_END_OK   = 2'd1,
    ST_END_MID  = 2'd2,
    ST_BAD_TREE = 2'd3
  } status_t;

  // Node word. The left child of an internal node is always the next node in
  // preorder, so only the right link is stored.
  typedef struct packed {
    logic              rv;
    node_idx_t         right;
    logic [SYM_W-1:0]  symbol;
    logic              leaf;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic      en;
    node_idx_t addr;
    node_t     data;
  } node_wr_t;

  typedef struct packed {
    logic      en;
    stk_addr_t addr;
    node_idx_t data;
  } stk_wr_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    status_t          status;
  } res_t;

endpackage

@@ src/htd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the decoder's input and result words.
// Depends on htd_pkg for field widths.
interface htd_in_if;
  logic                          valid;
  logic                          ready;
  logic [htd_pkg::OPCODE_W-1:0]  opcode;
  logic [htd_pkg::SYM_W-1:0]     value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface htd_out_if;
  logic                          valid;
  logic                          ready;
  logic [htd_pkg::SYM_W-1:0]     symbol;
  logic [htd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output symbol, output status, input ready);
  modport sink   (input valid, input symbol, input status, output ready);
endinterface

@@ src/huffman_tree_stream_decoder.sv @@
`timescale 1ns / 1ps
// Huffman tree stream decoder. Accepted words are registered in the execute stage;
// results then load the output register, held back while it stalls. Throughput is
// one word per cycle unless a bit or end word waits on the output or a tree byte
// fills a right child slot (its parent link takes the node RAM write port first).
// rst_n is synchronous, active low, and clears all control state; the node and slot
// RAMs are not cleared and need no clearing pass (only written entries are read).
module huffman_tree_stream_decoder (
  input logic       clk,
  input logic       rst_n,
  htd_in_if.sink    in_ch,
  htd_out_if.source out_ch
);

  htd_pkg::node_idx_t              node_raddr;
  htd_pkg::stk_addr_t              stk_raddr;
  htd_pkg::node_wr_t               node_wr;
  htd_pkg::stk_wr_t                stk_wr;
  htd_pkg::res_t                   res;
  logic [htd_pkg::NODE_W-1:0]      node_ram_q;
  htd_pkg::node_idx_t              stk_ram_q;
  htd_pkg::node_t                  node_rdata;
  htd_pkg::node_idx_t              stk_rdata;
  logic                            node_fwd_r, stk_fwd_r;
  htd_pkg::node_t                  node_fwd_data_r;
  htd_pkg::node_idx_t              stk_fwd_data_r;
  logic                            out_valid_r;
  logic [htd_pkg::SYM_W-1:0]       out_symbol_r;
  logic [htd_pkg::STATUS_W-1:0]    out_status_r;
  logic                            out_free;

  htd_ram #(
    .WIDTH (htd_pkg::NODE_W),
    .DEPTH (htd_pkg::NODE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_wr.en),
    .waddr (node_wr.addr),
    .wdata (node_wr.data),
    .raddr (node_raddr),
    .rdata (node_ram_q)
  );

  htd_ram #(
    .WIDTH (htd_pkg::NODE_AW),
    .DEPTH (htd_pkg::STACK_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (stk_wr.en),
    .waddr (stk_wr.addr),
    .wdata (stk_wr.data),
    .raddr (stk_raddr),
    .rdata (stk_ram_q)
  );

  // bypass a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_fwd_r <= 1'b0;
      stk_fwd_r  <= 1'b0;
    end else begin
      node_fwd_r <= node_wr.en && (node_wr.addr == node_raddr);
      stk_fwd_r  <= stk_wr.en && (stk_wr.addr == stk_raddr);
    end
  end

  always_ff @(posedge clk) begin
    node_fwd_data_r <= node_wr.data;
    stk_fwd_data_r  <= stk_wr.data;
  end

  assign node_rdata = node_fwd_r ? node_fwd_data_r : htd_pkg::node_t'(node_ram_q);
  assign stk_rdata  = stk_fwd_r ? stk_fwd_data_r : stk_ram_q;

  assign out_free = !out_valid_r || out_ch.ready;

  htd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_opcode  (in_ch.opcode),
    .in_value   (in_ch.value),
    .in_ready   (in_ch.ready),
    .out_free   (out_free),
    .node_rdata (node_rdata),
    .stk_rdata  (stk_rdata),
    .node_raddr (node_raddr),
    .stk_raddr  (stk_raddr),
    .node_wr    (node_wr),
    .stk_wr     (stk_wr),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_symbol_r <= res.symbol;
      out_status_r <= res.status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = out_symbol_r;
  assign out_ch.status = out_status_r;

endmodule

@@ src/htd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/htd_core.sv @@
`timescale 1ns / 1ps
// Execute stage of the decoder: tree rebuild, code bit walk, state registers
// and the address/write side of both memories. Depends on htd_pkg.
module htd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [htd_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [htd_pkg::SYM_W-1:0]    in_value,
  output logic                         in_ready,
  input  logic                         out_free,
  input  htd_pkg::node_t               node_rdata,
  input  htd_pkg::node_idx_t           stk_rdata,
  output htd_pkg::node_idx_t           node_raddr,
  output htd_pkg::stk_addr_t           stk_raddr,
  output htd_pkg::node_wr_t            node_wr,
  output htd_pkg::stk_wr_t             stk_wr,
  output htd_pkg::res_t                res
);

  // execute stage word
  logic                      b_valid_r, b_valid_nxt;
  htd_pkg::opcode_t          b_op_r;
  logic [htd_pkg::SYM_W-1:0] b_val_r;
  logic                      b_phase_r, b_phase_nxt;

  // decoder state
  htd_pkg::node_idx_t node_count_r, node_count_nxt;
  htd_pkg::node_idx_t cursor_r, cursor_nxt;
  htd_pkg::stk_cnt_t  rcount_r, rcount_nxt;
  logic               left_pend_r, left_pend_nxt;
  logic               awaiting_r, awaiting_nxt;
  logic               fault_r, fault_nxt;
  htd_pkg::node_t     cur_r, cur_nxt;
  htd_pkg::node_t     root_r, root_nxt;
  htd_pkg::node_idx_t node_raddr_r;
  htd_pkg::stk_addr_t stk_raddr_r;

  htd_pkg::stk_cnt_t  stack_top, avail, rd_slot, push_slot;
  htd_pkg::node_idx_t child_idx;
  logic nc_nz, tb_active, leaf_byte, mark_leaf, mark_int, bad_byte, sym_ok;
  logic add_req, overflow, add_ok, pop_right, first_write, emit_op, b_fire, in_fire;
  logic walk_bad, go_right, left_ok, right_ok, child_ok;

  assign nc_nz     = (node_count_r != '0);
  assign stack_top = rcount_r + htd_pkg::stk_cnt_t'(left_pend_r);
  assign avail     = stack_top - htd_pkg::stk_cnt_t'(nc_nz);

  // tree byte decode
  assign tb_active = b_valid_r && (b_op_r == htd_pkg::OP_TREE) && !fault_r &&
                     !(nc_nz && (stack_top == '0) && !awaiting_r);
  assign leaf_byte = tb_active && awaiting_r;
  assign mark_leaf = tb_active && !awaiting_r && (b_val_r == htd_pkg::CH_LEAF);
  assign mark_int  = tb_active && !awaiting_r && (b_val_r == htd_pkg::CH_INTERNAL);
  assign bad_byte  = tb_active && !awaiting_r && (b_val_r != htd_pkg::CH_LEAF) &&
                     (b_val_r != htd_pkg::CH_INTERNAL);
  assign sym_ok    = ({1'b0, b_val_r} < (htd_pkg::SYM_W+1)'(htd_pkg::SYMBOL_COUNT));
  assign add_req   = (leaf_byte && sym_ok) || mark_int;
  assign overflow  = (node_count_r >= htd_pkg::node_idx_t'(htd_pkg::MAX_NODES)) ||
                     (mark_int && (({1'b0, avail} + htd_pkg::stk_ext_t'(2)) >
                                   htd_pkg::stk_ext_t'(htd_pkg::STACK_DEPTH)));
  assign add_ok    = add_req && !overflow;
  // a right slot fill needs the parent written before the new node
  assign pop_right   = add_ok && nc_nz && !left_pend_r;
  assign first_write = pop_right && !b_phase_r;
  assign push_slot   = rcount_r - htd_pkg::stk_cnt_t'(pop_right);

  // code bit walk
  assign walk_bad  = fault_r || !nc_nz;
  assign go_right  = b_val_r[0];
  assign left_ok   = !cur_r.leaf && (({1'b0, cursor_r} + 1'b1) < {1'b0, node_count_r});
  assign right_ok  = !cur_r.leaf && cur_r.rv;
  assign child_ok  = go_right ? right_ok : left_ok;
  assign child_idx = go_right ? cur_r.right : cursor_r + 1'b1;

  assign emit_op  = (b_op_r == htd_pkg::OP_BIT) || (b_op_r == htd_pkg::OP_END);
  assign b_fire   = b_valid_r && !first_write && (!emit_op || out_free);
  assign in_ready = !b_valid_r || b_fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    node_wr = '0;
    if (first_write) begin
      node_wr.en         = 1'b1;
      node_wr.addr       = stk_rdata;
      node_wr.data.rv    = 1'b1;
      node_wr.data.right = node_count_r;
    end else if (b_fire && add_ok) begin
      node_wr.en          = 1'b1;
      node_wr.addr        = node_count_r;
      node_wr.data.leaf   = leaf_byte;
      node_wr.data.symbol = leaf_byte ? b_val_r : '0;
    end
  end

  always_comb begin
    stk_wr      = '0;
    stk_wr.en   = b_fire && add_ok && mark_int;
    stk_wr.addr = push_slot[htd_pkg::STACK_AW-1:0];
    stk_wr.data = node_count_r;
  end

  always_comb begin
    node_count_nxt = node_count_r;
    cursor_nxt     = cursor_r;
    rcount_nxt     = rcount_r;
    left_pend_nxt  = left_pend_r;
    awaiting_nxt   = awaiting_r;
    fault_nxt      = fault_r;
    // keep the cached cursor and root words coherent with table writes
    cur_nxt        = (node_wr.en && (node_wr.addr == cursor_r)) ? node_wr.data : cur_r;
    root_nxt       = (node_wr.en && (node_wr.addr == '0)) ? node_wr.data : root_r;
    res.valid      = 1'b0;
    res.symbol     = '0;
    res.status     = htd_pkg::ST_SYMBOL;
    if (b_fire) begin
      unique case (b_op_r)
        htd_pkg::OP_TREE: begin
          if (leaf_byte) begin
            awaiting_nxt = 1'b0;
          end
          if (mark_leaf) begin
            awaiting_nxt = 1'b1;
          end
          if (bad_byte || (leaf_byte && !sym_ok) || (add_req && overflow)) begin
            fault_nxt = 1'b1;
          end
          if (add_ok) begin
            node_count_nxt = node_count_r + 1'b1;
            rcount_nxt     = push_slot + htd_pkg::stk_cnt_t'(mark_int);
            left_pend_nxt  = mark_int;
          end
        end
        htd_pkg::OP_BIT: begin
          res.valid = 1'b1;
          if (walk_bad || !child_ok) begin
            res.status = htd_pkg::ST_BAD_TREE;
            cursor_nxt = '0;
            cur_nxt    = root_r;
          end else if (node_rdata.leaf) begin
            res.symbol = node_rdata.symbol;
            cursor_nxt = '0;
            cur_nxt    = root_r;
          end else begin
            // descend: no word for an inner node
            res.valid  = 1'b0;
            cursor_nxt = child_idx;
            cur_nxt    = node_rdata;
          end
        end
        htd_pkg::OP_END: begin
          res.valid = 1'b1;
          if (walk_bad) begin
            res.status = htd_pkg::ST_BAD_TREE;
          end else if (cursor_r != '0) begin
            res.status = htd_pkg::ST_END_MID;
          end else begin
            res.status = htd_pkg::ST_END_OK;
          end
          cursor_nxt = '0;
          cur_nxt    = root_r;
        end
        htd_pkg::OP_CLEAR: begin
          node_count_nxt = '0;
          cursor_nxt     = '0;
          rcount_nxt     = '0;
          left_pend_nxt  = 1'b0;
          awaiting_nxt   = 1'b0;
          fault_nxt      = 1'b0;
        end
        default: begin
          fault_nxt = fault_r;
        end
      endcase
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (in_fire) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire) begin
      b_valid_nxt = 1'b0;
    end
    b_phase_nxt = b_phase_r;
    if (b_fire) begin
      b_phase_nxt = 1'b0;
    end else if (first_write) begin
      b_phase_nxt = 1'b1;
    end
  end

  // Issue reads for the incoming word from next-state values; hold otherwise.
  assign rd_slot    = rcount_nxt - 1'b1;
  assign node_raddr = in_fire ? (in_value[0] ? cur_nxt.right : cursor_nxt + 1'b1)
                              : node_raddr_r;
  assign stk_raddr  = in_fire ? rd_slot[htd_pkg::STACK_AW-1:0] : stk_raddr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r    <= 1'b0;
      b_phase_r    <= 1'b0;
      node_count_r <= '0;
      cursor_r     <= '0;
      rcount_r     <= '0;
      left_pend_r  <= 1'b0;
      awaiting_r   <= 1'b0;
      fault_r      <= 1'b0;
    end else begin
      b_valid_r    <= b_valid_nxt;
      b_phase_r    <= b_phase_nxt;
      node_count_r <= node_count_nxt;
      cursor_r     <= cursor_nxt;
      rcount_r     <= rcount_nxt;
      left_pend_r  <= left_pend_nxt;
      awaiting_r   <= awaiting_nxt;
      fault_r      <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_op_r  <= htd_pkg::opcode_t'(in_opcode);
      b_val_r <= in_value;
    end
    cur_r        <= cur_nxt;
    root_r       <= root_nxt;
    node_raddr_r <= node_raddr;
    stk_raddr_r  <= stk_raddr;
  end

endmodule

@@ src/htd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the Huffman tree stream decoder, bound to the top level.
// Depends on htd_pkg and huffman_tree_stream_decoder.
module htd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [htd_pkg::OPCODE_W-1:0] in_opcode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [htd_pkg::SYM_W-1:0]    out_symbol,
  input logic [htd_pkg::STATUS_W-1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_status))
    else $error("result word changed while stalled");

  a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != htd_pkg::ST_SYMBOL) |-> out_symbol == '0)
    else $error("nonzero symbol on a status word");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == htd_pkg::OP_END)) ##1 (!out_valid || out_ready)
    |=> out_valid && (out_status != htd_pkg::ST_SYMBOL))
    else $error("end of data did not yield an end status");

  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid || $past(in_valid && in_ready))
    else $error("input held off without a pending word");

endmodule

bind huffman_tree_stream_decoder htd_checker u_htd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_opcode  (in_ch.opcode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_symbol (out_ch.symbol),
  .out_status (out_ch.status)
);
